>>> rtl/dlps_pkg.sv
`timescale 1ns / 1ps
package dlps_pkg;

	// store depth is a power of two: addresses wrap on ADDR_W bits
	localparam int STORE_DEPTH   = 4096;
	localparam int WINDOW_LENGTH = 2048;
	localparam int ADDR_W        = $clog2(STORE_DEPTH);
	localparam int SAMPLE_W      = 16;
	localparam int PHASE_W       = 32;
	localparam int FRAC_W        = 15;
	localparam int HI_W          = 16;
	localparam int WIN_W         = $clog2(WINDOW_LENGTH + 1);
	localparam int MUL_A_W       = SAMPLE_W + 1;
	localparam int MUL_B_W       = FRAC_W + 1;
	localparam int PROD_W        = MUL_A_W + MUL_B_W;
	localparam int ACC_W         = SAMPLE_W + 2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		sample_t           wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_op_t;

	// integer tap delay from the top phase bits, reduced to the store
	function automatic logic [ADDR_W-1:0] tap_delay(input logic [HI_W-1:0] hi);
		logic [HI_W+WIN_W-1:0] prod;
		prod = (HI_W + WIN_W)'(hi) * (HI_W + WIN_W)'(WINDOW_LENGTH);
		return ADDR_W'(prod >> HI_W);
	endfunction

endpackage

>>> rtl/dlps_ram.sv
`timescale 1ns / 1ps
module dlps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/dlps_mul.sv
`timescale 1ns / 1ps
module dlps_mul
	import dlps_pkg::*;
(
	input  logic                     clk,
	input  mul_op_t                  op,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op.a) * PROD_W'(op.b);
	end

	assign prod = prod_q;

endmodule

>>> rtl/dlps_ctrl.sv
`timescale 1ns / 1ps
module dlps_ctrl
	import dlps_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  sample_t                  in_sample,
	input  logic [PHASE_W-1:0]       rate,
	input  logic                     out_free,
	output logic                     out_load,
	output sample_t                  out_sample,
	output ram_req_t                 ram_req,
	input  sample_t                  ram_rdata,
	output mul_op_t                  mul_op,
	input  logic signed [PROD_W-1:0] mul_prod
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_CAP1,
		ST_MULF,
		ST_INTERP,
		ST_MULG,
		ST_ACC,
		ST_OUT
	} state_t;

	state_t                   state_q;
	logic                     tap_q;
	logic                     full_q;
	logic                     rvalid_q;
	logic [ADDR_W-1:0]        wp_q;
	logic [PHASE_W-1:0]       phase_q;
	sample_t                  v0_q;
	sample_t                  v1_q;
	sample_t                  val_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic [HI_W-1:0]          hi;
	logic [FRAC_W-1:0]        frac;
	logic [FRAC_W-1:0]        gain;
	logic [ADDR_W-1:0]        idx0;
	logic [ADDR_W-1:0]        raddr;
	logic                     accept;
	sample_t                  rd_val;
	logic signed [ACC_W-1:0]  prod_sh;
	logic signed [ACC_W-1:0]  acc_sum;
	sample_t                  sat;

	// second tap sits half a window cycle ahead
	assign hi   = {phase_q[PHASE_W-1] ^ tap_q, phase_q[PHASE_W-2:PHASE_W-HI_W]};
	assign frac = phase_q[FRAC_W+5:6];
	assign gain = hi[HI_W-1] ? ~hi[FRAC_W-1:0] : hi[FRAC_W-1:0];
	assign idx0 = wp_q - tap_delay(hi);
	assign raddr = (state_q == ST_RD1) ? idx0 - ADDR_W'(1) : idx0;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign ram_req.we    = accept;
	assign ram_req.waddr = wp_q;
	assign ram_req.wdata = in_sample;
	assign ram_req.raddr = raddr;

	// entries never written since reset read as zero
	assign rd_val = rvalid_q ? ram_rdata : '0;

	always_comb begin
		mul_op.a = MUL_A_W'(val_q);
		mul_op.b = {1'b0, gain};
		if (state_q == ST_MULF) begin
			mul_op.a = MUL_A_W'(v1_q) - MUL_A_W'(v0_q);
			mul_op.b = {1'b0, frac};
		end
	end

	// floor shift by 15
	assign prod_sh = $signed(mul_prod[PROD_W-1:FRAC_W]);
	assign acc_sum = tap_q ? acc_q + prod_sh : prod_sh;

	always_comb begin
		if (acc_q > ACC_W'(32767)) begin
			sat = 16'sh7FFF;
		end else if (acc_q < -ACC_W'(32768)) begin
			sat = 16'sh8000;
		end else begin
			sat = acc_q[SAMPLE_W-1:0];
		end
	end

	assign out_sample = sat;
	assign out_load   = (state_q == ST_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tap_q    <= 1'b0;
			full_q   <= 1'b0;
			rvalid_q <= 1'b0;
			wp_q     <= '0;
			phase_q  <= '0;
		end else begin
			rvalid_q <= full_q || (raddr <= wp_q);
			unique case (state_q)
				ST_IDLE: begin
					tap_q <= 1'b0;
					if (accept) begin
						state_q <= ST_RD0;
					end
				end
				ST_RD0: begin
					state_q <= ST_RD1;
				end
				ST_RD1: begin
					state_q <= ST_CAP1;
				end
				ST_CAP1: begin
					state_q <= ST_MULF;
				end
				ST_MULF: begin
					state_q <= ST_INTERP;
				end
				ST_INTERP: begin
					state_q <= ST_MULG;
				end
				ST_MULG: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					tap_q   <= 1'b1;
					state_q <= tap_q ? ST_OUT : ST_RD0;
				end
				ST_OUT: begin
					if (out_free) begin
						wp_q    <= wp_q + ADDR_W'(1);
						phase_q <= phase_q + rate;
						if (wp_q == ADDR_W'(STORE_DEPTH - 1)) begin
							full_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD1) begin
			v0_q <= rd_val;
		end
		if (state_q == ST_CAP1) begin
			v1_q <= rd_val;
		end
		if (state_q == ST_INTERP) begin
			val_q <= SAMPLE_W'(ACC_W'(v0_q) + prod_sh);
		end
		if (state_q == ST_ACC) begin
			acc_q <= acc_sum;
		end
	end

endmodule

>>> rtl/delay_line_pitch_shifter_core.sv
`timescale 1ns / 1ps
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------
// s_axis   | s_tvalid / s_tready       | s_tdata[15:0] sample_in
// m_axis   | m_tvalid / m_tready       | m_tdata[15:0] sample_out
// cfg      | cfg_valid / cfg_ready     | cfg_data[31:0] phase_rate
//
// one sample passes from acceptance to the result register in two taps of
// seven steps each on one read port and one shared multiplier, plus writeback.
// a new sample is accepted only in idle, after the last one has been written back.
// reset clears control state; the delay store is not swept, a wrap flag and
// the write pointer mark which entries hold samples, others read as zero.
// a held result stalls the block only at writeback; the next sample can be taken
// while it waits.
module delay_line_pitch_shifter_core
	import dlps_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,   // [15:0] sample_in
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,   // [15:0] sample_out
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [PHASE_W-1:0]  cfg_data
);

	logic [PHASE_W-1:0]       rate_q;
	logic                     m_tvalid_q;
	sample_t                  m_tdata_q;
	logic                     out_free;
	logic                     out_load;
	sample_t                  out_sample;
	ram_req_t                 ram_req;
	sample_t                  ram_rdata;
	mul_op_t                  mul_op;
	logic signed [PROD_W-1:0] mul_prod;

	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				rate_q <= cfg_data;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= out_sample;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	dlps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_sample  (s_tdata),
		.rate       (rate_q),
		.out_free   (out_free),
		.out_load   (out_load),
		.out_sample (out_sample),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.mul_op     (mul_op),
		.mul_prod   (mul_prod)
	);

	dlps_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	dlps_mul u_mul (
		.clk  (clk),
		.op   (mul_op),
		.prod (mul_prod)
	);

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import dlps_pkg::*;

	typedef enum logic {ROW_SAMPLE, ROW_RATE} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] value;   // sample in the low half, or a rate
		logic        known;
		logic [15:0] want;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 25;
	localparam int SETTLE_CYCLES = 20;

	// rate zero right after reset: gain of the first tap is zero and the second tap
	// reads 1024 entries back, still empty, so the output is zero
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_SAMPLE, 32'h0000_0000, 1'b1, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_7FFF, 1'b1, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_8000, 1'b1, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_FFFF, 1'b1, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_0001, 1'b1, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_5555, 1'b1, 16'h0000},
		// slow sweep: the first items hit a tap delay of zero
		'{ROW_RATE,   32'h0010_0000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_7FFF, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_8000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_7FFF, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_8000, 1'b0, 16'h0000},
		'{ROW_RATE,   32'h0020_0000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_AAAA, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_7FFF, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_8000, 1'b0, 16'h0000},
		'{ROW_RATE,   32'h8000_0000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_7FFF, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_8000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_1234, 1'b0, 16'h0000},
		'{ROW_RATE,   32'h7FFF_FFFF, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_8000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_7FFF, 1'b0, 16'h0000},
		'{ROW_RATE,   32'hFFFF_FFFF, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_7FFF, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 32'h0000_0000, 1'b0, 16'h0000}
	};

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [15:0]        s_tdata   = '0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [15:0]        m_tdata;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [PHASE_W-1:0] cfg_data  = '0;

	// shifter state as the design should hold it
	sample_t            history [STORE_DEPTH];
	logic [ADDR_W-1:0]  wr_ptr    = '0;
	logic [31:0]        phase_acc = '0;
	logic [31:0]        phase_step = '0;

	logic [15:0]        pending_out_q [$];
	int                 mismatches = 0;
	bit                 tx_burst   = 1'b0;
	bit                 rx_burst   = 1'b0;
	logic [15:0]        ramp       = '0;

	delay_line_pitch_shifter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	task automatic mismatch_report(input string msg);
		$display("[%0t] %s", $realtime, msg);
		mismatches++;
	endtask

	// one interpolated, gain-weighted tap; shifts by 15 floor on signed values
	function automatic longint tap_mix(input logic [31:0] ph);
		logic [15:0]       hi;
		logic [31:0]       span;
		logic [ADDR_W-1:0] lag;
		logic [ADDR_W-1:0] i0;
		logic [ADDR_W-1:0] i1;
		longint            gain;
		longint            fr;
		longint            v0;
		longint            v1;
		longint            val;
		hi   = ph[31:16];
		gain = hi[15] ? longint'(16'hFFFF - hi) : longint'(hi);
		span = 32'(hi) * 32'(WINDOW_LENGTH);
		lag  = span[16 +: ADDR_W];
		fr   = longint'(ph[20:6]);
		i0   = wr_ptr - lag;
		i1   = i0 - 1'b1;
		v0   = longint'(history[i0]);
		v1   = longint'(history[i1]);
		val  = v0 + (((v1 - v0) * fr) >>> 15);
		return (val * gain) >>> 15;
	endfunction

	function automatic logic [15:0] shift_predict(input logic [15:0] smp);
		longint acc;
		history[wr_ptr] = sample_t'(smp);
		acc = tap_mix(phase_acc) + tap_mix(phase_acc + 32'h8000_0000);
		if (acc > 32767)
			acc = 32767;
		else if (acc < -32768)
			acc = -32768;
		wr_ptr    = wr_ptr + 1'b1;
		phase_acc = phase_acc + phase_step;
		return acc[15:0];
	endfunction

	function automatic logic [15:0] pick_sample();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 2)
			return 16'h7FFF;
		if (sel < 4)
			return 16'h8000;
		if (sel < 9) begin
			// slowly moving signal so the interpolation sees small differences
			ramp = ramp + 16'($urandom_range(0, 512)) - 16'd256;
			return ramp;
		end
		return 16'($urandom);
	endfunction

	// returns at the edge of the transaction
	task automatic push_sample(input logic [15:0] smp, input bit known, input logic [15:0] want);
		int          gap;
		logic [15:0] predicted;
		gap = tx_burst ? 0 : $urandom_range(0, 10);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = shift_predict(smp);
		pending_out_q.push_back(known ? want : predicted);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_out_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(input logic [31:0] rate);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= rate;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid  <= 1'b0;
		phase_step = rate;
	endtask

	// result side
	initial begin
		int          stall;
		int          taken;
		logic [15:0] want;
		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 10);
			repeat (stall) begin
				m_tready <= 1'b0;
				@(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			if (pending_out_q.size() == 0) begin
				mismatch_report($sformatf("unexpected sample_out %h", m_tdata));
			end else begin
				want = pending_out_q.pop_front();
				if (m_tdata !== want)
					mismatch_report($sformatf("sample_out %h, predicted %h", m_tdata, want));
			end
			taken++;
			if (taken % 40 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		logic [31:0] rate;
		for (int i = 0; i < STORE_DEPTH; i++)
			history[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (DIRECTED[r].kind == ROW_RATE)
				write_rate(DIRECTED[r].value);
			else
				push_sample(DIRECTED[r].value[15:0], DIRECTED[r].known, DIRECTED[r].want);
		end

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: rate = $urandom_range(0, 32'h0008_0000);
				1: rate = -$urandom_range(1, 32'h0008_0000);
				3: rate = 32'h0;
				default: rate = $urandom;
			endcase
			write_rate(rate);
			for (int n = 0; n < 100; n++) begin
				if (n % 25 == 0)
					tx_burst = ($urandom_range(0, 3) == 0);
				// let the result side empty out with no sample offered
				if (p == 2 && n == 50)
					wait_drained();
				push_sample(pick_sample(), 1'b0, 16'h0000);
			end
		end

		wait_drained();
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
